/* src/elc_pkg.sv */
package elc_pkg;

    // Operating modes, one-hot inside the block.
    typedef enum logic [5:0] {
        MODE_IDLE  = 6'b000001,
        MODE_UP    = 6'b000010,
        MODE_DOWN  = 6'b000100,
        MODE_EWAIT = 6'b001000,
        MODE_EDESC = 6'b010000,
        MODE_DWAIT = 6'b100000
    } mode_t;

    // Mode numbers as reported on the result word.
    localparam logic [2:0] CODE_IDLE  = 3'd0;
    localparam logic [2:0] CODE_UP    = 3'd1;
    localparam logic [2:0] CODE_DOWN  = 3'd2;
    localparam logic [2:0] CODE_EWAIT = 3'd3;
    localparam logic [2:0] CODE_EDESC = 3'd4;
    localparam logic [2:0] CODE_DWAIT = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_BLINK_HALF_PERIOD = 1'b0;
    localparam logic CFG_DIAG_PULSE_LIMIT  = 1'b1;

    localparam logic [15:0] BLINK_HALF_PERIOD_RST = 16'd1000;
    localparam logic [7:0]  DIAG_PULSE_LIMIT_RST  = 8'd3;

    typedef struct packed {
        mode_t       run_mode;
        logic [1:0]  travel_target;
        logic [1:0]  saved_travel;
        logic [15:0] blink_count;
        logic        blink_on;
        logic [7:0]  pulse_count;
        logic        emergency_pending;
        logic        diag_pending;
        logic [1:0]  shown_floor;
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       diag_led;
        logic       emergency_led;
        logic [1:0] floor_display;
        logic       motor_down;
        logic       motor_up;
    } result_t;

    function automatic logic [2:0] mode_code(mode_t m);
        logic [2:0] c;
        case (m)
            MODE_IDLE:  c = CODE_IDLE;
            MODE_UP:    c = CODE_UP;
            MODE_DOWN:  c = CODE_DOWN;
            MODE_EWAIT: c = CODE_EWAIT;
            MODE_EDESC: c = CODE_EDESC;
            MODE_DWAIT: c = CODE_DWAIT;
            default:    c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

/* src/elc_step.sv */
module elc_step (
    input  elc_pkg::ctrl_state_t cur_i,
    input  logic [15:0]          blink_half_period_i,
    input  logic [7:0]           diag_pulse_limit_i,
    input  logic [2:0]           floor_sensors_i,
    input  logic [6:0]           call_buttons_i,
    input  logic                 emergency_event_i,
    input  logic                 diag_pulse_i,
    input  logic                 resume_button_i,
    input  logic                 ms_tick_i,
    output elc_pkg::ctrl_state_t next_o,
    output elc_pkg::result_t     result_o
);
    import elc_pkg::*;

    ctrl_state_t st;
    logic [15:0] half;
    logic [7:0]  limit;
    logic        c1, c2, c3;
    logic        blink_done;
    logic        at_target;

    assign half  = (blink_half_period_i == 16'd0) ? 16'd1 : blink_half_period_i;
    assign limit = (diag_pulse_limit_i == 8'd0) ? 8'd1 : diag_pulse_limit_i;
    assign c1 = |call_buttons_i[1:0];
    assign c2 = |call_buttons_i[4:2];
    assign c3 = |call_buttons_i[6:5];

    always_comb begin
        st         = cur_i;
        blink_done = 1'b0;
        at_target  = 1'b0;

        // Diagnostic pulses are counted first.
        if (diag_pulse_i && st.run_mode != MODE_DWAIT) begin
            st.pulse_count = st.pulse_count + 8'd1;
            if (st.pulse_count >= limit) begin
                st.pulse_count  = 8'd0;
                st.diag_pending = 1'b1;
            end
        end

        // Then the emergency edge.
        if (emergency_event_i) begin
            if (st.run_mode == MODE_IDLE || st.run_mode == MODE_UP
                    || st.run_mode == MODE_DOWN) begin
                st.saved_travel = 2'(mode_code(st.run_mode));
                st.run_mode     = MODE_EWAIT;
                st.blink_count  = 16'd0;
                st.blink_on     = 1'b1;
            end else if (st.run_mode == MODE_DWAIT) begin
                st.emergency_pending = 1'b1;
            end
        end

        // Pending stops are served while the car is in normal service.
        if (st.run_mode == MODE_IDLE || st.run_mode == MODE_UP
                || st.run_mode == MODE_DOWN) begin
            if (st.emergency_pending) begin
                st.emergency_pending = 1'b0;
                st.saved_travel      = 2'(mode_code(st.run_mode));
                st.run_mode          = MODE_EWAIT;
                st.blink_count       = 16'd0;
                st.blink_on          = 1'b1;
            end else if (st.diag_pending) begin
                st.diag_pending = 1'b0;
                st.saved_travel = 2'(mode_code(st.run_mode));
                st.run_mode     = MODE_DWAIT;
                st.blink_count  = 16'd0;
                st.blink_on     = 1'b1;
            end
        end

        // Blink advance shared by both wait modes; only used there.
        if ((st.run_mode == MODE_EWAIT || st.run_mode == MODE_DWAIT) && ms_tick_i) begin
            st.blink_count = st.blink_count + 16'd1;
            if (st.blink_count >= half) begin
                st.blink_count = 16'd0;
                st.blink_on    = ~st.blink_on;
                blink_done     = st.blink_on && resume_button_i;
            end
        end

        case (st.travel_target)
            2'd1:    at_target = floor_sensors_i[0];
            2'd2:    at_target = floor_sensors_i[1];
            2'd3:    at_target = floor_sensors_i[2];
            default: at_target = 1'b0;
        endcase

        case (st.run_mode)
            MODE_IDLE: begin
                if (floor_sensors_i[0]) begin
                    st.shown_floor = 2'd1;
                    if (c2) begin
                        st.travel_target = 2'd2;
                        st.run_mode      = MODE_UP;
                    end else if (c3) begin
                        st.travel_target = 2'd3;
                        st.run_mode      = MODE_UP;
                    end
                end else if (floor_sensors_i[1]) begin
                    st.shown_floor = 2'd2;
                    if (c1) begin
                        st.travel_target = 2'd1;
                        st.run_mode      = MODE_DOWN;
                    end else if (c3) begin
                        st.travel_target = 2'd3;
                        st.run_mode      = MODE_UP;
                    end
                end else if (floor_sensors_i[2]) begin
                    st.shown_floor = 2'd3;
                    if (c1) begin
                        st.travel_target = 2'd1;
                        st.run_mode      = MODE_DOWN;
                    end else if (c2) begin
                        st.travel_target = 2'd2;
                        st.run_mode      = MODE_DOWN;
                    end
                end
            end
            MODE_UP, MODE_DOWN: begin
                if (at_target) begin
                    st.run_mode = MODE_IDLE;
                end
            end
            MODE_EWAIT: begin
                if (blink_done) begin
                    st.blink_on    = 1'b0;
                    st.blink_count = 16'd0;
                    st.run_mode    = MODE_EDESC;
                end
            end
            MODE_EDESC: begin
                if (|floor_sensors_i[1:0]) begin
                    st.shown_floor = floor_sensors_i[1] ? 2'd2 : 2'd1;
                    if (st.diag_pending) begin
                        st.diag_pending = 1'b0;
                        st.run_mode     = MODE_DWAIT;
                        st.blink_count  = 16'd0;
                        st.blink_on     = 1'b1;
                    end else begin
                        st.run_mode = (st.saved_travel == CODE_UP[1:0])   ? MODE_UP :
                                      (st.saved_travel == CODE_DOWN[1:0]) ? MODE_DOWN :
                                                                            MODE_IDLE;
                        st.saved_travel = 2'd0;
                        st.blink_on     = 1'b0;
                        st.blink_count  = 16'd0;
                    end
                end
            end
            MODE_DWAIT: begin
                if (blink_done) begin
                    st.pulse_count = 8'd0;
                    if (st.emergency_pending) begin
                        st.emergency_pending = 1'b0;
                        st.run_mode          = MODE_EWAIT;
                        st.blink_count       = 16'd0;
                        st.blink_on          = 1'b1;
                    end else begin
                        st.run_mode = (st.saved_travel == CODE_UP[1:0])   ? MODE_UP :
                                      (st.saved_travel == CODE_DOWN[1:0]) ? MODE_DOWN :
                                                                            MODE_IDLE;
                        st.saved_travel = 2'd0;
                        st.blink_on     = 1'b0;
                        st.blink_count  = 16'd0;
                    end
                end
            end
            default: begin
                st.run_mode = MODE_IDLE;
            end
        endcase

        next_o = st;

        result_o.motor_up      = (st.run_mode == MODE_UP);
        result_o.motor_down    = (st.run_mode == MODE_DOWN) || (st.run_mode == MODE_EDESC);
        result_o.floor_display = st.shown_floor;
        result_o.emergency_led = (st.run_mode == MODE_EWAIT) && st.blink_on;
        result_o.diag_led      = (st.run_mode == MODE_DWAIT) && st.blink_on;
        result_o.mode          = mode_code(st.run_mode);
    end

endmodule

/* src/three_floor_elevator_controller.sv */
// Three-floor elevator controller. Each input word is one sample of the car's
// pins: floor sensors, call buttons, the emergency and diagnostic edges, the
// resume button and a blink time tick. For every accepted word the block
// updates its controller state and returns exactly one result word with the
// motor drives, the floor display, the two indicator LEDs and the mode number.
// The whole state update for a word is a single pass of combinational logic
// from the state registers to the result register, so a new word is taken on
// every clock while the result side keeps up, and the result register alone
// decides back-pressure. Blink timing counts ms_tick samples, not clocks. The
// configuration port writes blink_half_period (index 0) and diag_pulse_limit
// (index 1) and should only be used while no word is in flight.
module three_floor_elevator_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    // From bit 0: floor_sensors[2:0], call_buttons[9:3], emergency_event[10],
    // diag_pulse[11], resume_button[12], ms_tick[13], zero[15:14].
    input  logic [15:0] s_tdata,
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0: motor_up[0], motor_down[1], floor_display[3:2],
    // emergency_led[4], diag_led[5], mode[8:6], zero[15:9].
    output logic [15:0] m_tdata,
    // Configuration writes.
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import elc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    result_t     result_next;
    logic [15:0] blink_half_period_reg;
    logic [7:0]  diag_pulse_limit_reg;
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic        accept;

    // A word enters whenever the result register is empty or being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    elc_step u_step (
        .cur_i               (state_reg),
        .blink_half_period_i (blink_half_period_reg),
        .diag_pulse_limit_i  (diag_pulse_limit_reg),
        .floor_sensors_i     (s_tdata[2:0]),
        .call_buttons_i      (s_tdata[9:3]),
        .emergency_event_i   (s_tdata[10]),
        .diag_pulse_i        (s_tdata[11]),
        .resume_button_i     (s_tdata[12]),
        .ms_tick_i           (s_tdata[13]),
        .next_o              (state_next),
        .result_o            (result_next)
    );

    // Controller state, configuration and the result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.run_mode          <= MODE_IDLE;
            state_reg.travel_target     <= 2'd0;
            state_reg.saved_travel      <= 2'd0;
            state_reg.blink_count       <= 16'd0;
            state_reg.blink_on          <= 1'b0;
            state_reg.pulse_count       <= 8'd0;
            state_reg.emergency_pending <= 1'b0;
            state_reg.diag_pending      <= 1'b0;
            state_reg.shown_floor       <= 2'd0;
            blink_half_period_reg       <= BLINK_HALF_PERIOD_RST;
            diag_pulse_limit_reg        <= DIAG_PULSE_LIMIT_RST;
            m_tvalid_reg                <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_BLINK_HALF_PERIOD: blink_half_period_reg <= cfg_wdata;
                    CFG_DIAG_PULSE_LIMIT:  diag_pulse_limit_reg  <= cfg_wdata[7:0];
                    default:               blink_half_period_reg <= blink_half_period_reg;
                endcase
            end
            if (accept) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted word.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {7'd0, result_next.mode, result_next.diag_led,
                            result_next.emergency_led, result_next.floor_display,
                            result_next.motor_down, result_next.motor_up};
        end
    end

endmodule

/* verif/elevator_checker.sv */
`timescale 1ns / 100ps

// Watches both streams of the elevator controller, keeps its own copy of the
// controller state and checks every result word against the predicted one.
module elevator_checker
    import elc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          mismatch_count,
    output int          outputs_pending
);

    logic [15:0] half_period_reg;
    logic [7:0]  pulse_limit_reg;

    logic [2:0]  car_mode;
    logic [1:0]  target_floor;
    logic [1:0]  interrupted_travel;
    logic [15:0] blink_ticks;
    logic        led_phase;
    logic [7:0]  pulses_seen;
    logic        emer_waiting;
    logic        diag_waiting;
    logic [1:0]  display_floor;

    result_t expected_car_outputs [$];

    task automatic begin_blink_wait(input logic [2:0] wait_mode);
        car_mode    = wait_mode;
        blink_ticks = '0;
        led_phase   = 1'b1;
    endtask

    // One tick moves the blink; a full on/off cycle ending with resume held
    // releases the wait.
    task automatic advance_blink(input logic tick, input logic resume,
                                 output logic released);
        logic [15:0] half;
        half = (half_period_reg == 16'd0) ? 16'd1 : half_period_reg;
        released = 1'b0;
        if (tick) begin
            blink_ticks = blink_ticks + 16'd1;
            if (blink_ticks >= half) begin
                blink_ticks = '0;
                led_phase   = ~led_phase;
                released    = led_phase && resume;
            end
        end
    endtask

    task automatic return_to_travel();
        car_mode = ({1'b0, interrupted_travel} <= CODE_DOWN) ? {1'b0, interrupted_travel}
                                                             : CODE_IDLE;
        interrupted_travel = '0;
        led_phase   = 1'b0;
        blink_ticks = '0;
    endtask

    task automatic head_for(input logic [1:0] here, input logic [1:0] dest);
        target_floor = dest;
        car_mode     = (dest > here) ? CODE_UP : CODE_DOWN;
    endtask

    task automatic step_car_controller(input logic [15:0] w, output result_t r);
        logic [2:0] sens;
        logic [6:0] calls;
        logic       emer, pulse, resume, tick;
        logic       c1, c2, c3;
        logic [7:0] limit;
        logic       released;
        sens   = w[2:0];
        calls  = w[9:3];
        emer   = w[10];
        pulse  = w[11];
        resume = w[12];
        tick   = w[13];
        c1 = |calls[1:0];
        c2 = |calls[4:2];
        c3 = |calls[6:5];
        limit = (pulse_limit_reg == 8'd0) ? 8'd1 : pulse_limit_reg;

        // Pulses first, then the emergency edge, then the mode logic.
        if (pulse && car_mode != CODE_DWAIT) begin
            pulses_seen = pulses_seen + 8'd1;
            if (pulses_seen >= limit) begin
                pulses_seen  = '0;
                diag_waiting = 1'b1;
            end
        end
        if (emer) begin
            if (car_mode <= CODE_DOWN) begin
                interrupted_travel = car_mode[1:0];
                begin_blink_wait(CODE_EWAIT);
            end else if (car_mode == CODE_DWAIT) begin
                emer_waiting = 1'b1;
            end
        end
        if (car_mode <= CODE_DOWN) begin
            if (emer_waiting) begin
                emer_waiting = 1'b0;
                interrupted_travel = car_mode[1:0];
                begin_blink_wait(CODE_EWAIT);
            end else if (diag_waiting) begin
                diag_waiting = 1'b0;
                interrupted_travel = car_mode[1:0];
                begin_blink_wait(CODE_DWAIT);
            end
        end

        case (car_mode)
            CODE_IDLE: begin
                if (sens[0]) begin
                    display_floor = 2'd1;
                    if (c2) head_for(2'd1, 2'd2);
                    else if (c3) head_for(2'd1, 2'd3);
                end else if (sens[1]) begin
                    display_floor = 2'd2;
                    if (c1) head_for(2'd2, 2'd1);
                    else if (c3) head_for(2'd2, 2'd3);
                end else if (sens[2]) begin
                    display_floor = 2'd3;
                    if (c1) head_for(2'd3, 2'd1);
                    else if (c2) head_for(2'd3, 2'd2);
                end
            end
            CODE_UP, CODE_DOWN: begin
                if (target_floor != 2'd0 && sens[target_floor - 2'd1])
                    car_mode = CODE_IDLE;
            end
            CODE_EWAIT: begin
                advance_blink(tick, resume, released);
                if (released) begin
                    led_phase   = 1'b0;
                    blink_ticks = '0;
                    car_mode    = CODE_EDESC;
                end
            end
            CODE_EDESC: begin
                if (|sens[1:0]) begin
                    display_floor = sens[1] ? 2'd2 : 2'd1;
                    if (diag_waiting) begin
                        diag_waiting = 1'b0;
                        begin_blink_wait(CODE_DWAIT);
                    end else begin
                        return_to_travel();
                    end
                end
            end
            CODE_DWAIT: begin
                advance_blink(tick, resume, released);
                if (released) begin
                    pulses_seen = '0;
                    if (emer_waiting) begin
                        emer_waiting = 1'b0;
                        begin_blink_wait(CODE_EWAIT);
                    end else begin
                        return_to_travel();
                    end
                end
            end
            default: car_mode = CODE_IDLE;
        endcase

        r.motor_up      = (car_mode == CODE_UP);
        r.motor_down    = (car_mode == CODE_DOWN) || (car_mode == CODE_EDESC);
        r.floor_display = display_floor;
        r.emergency_led = (car_mode == CODE_EWAIT) ? led_phase : 1'b0;
        r.diag_led      = (car_mode == CODE_DWAIT) ? led_phase : 1'b0;
        r.mode          = car_mode;
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            half_period_reg    = BLINK_HALF_PERIOD_RST;
            pulse_limit_reg    = DIAG_PULSE_LIMIT_RST;
            car_mode           = CODE_IDLE;
            target_floor       = '0;
            interrupted_travel = '0;
            blink_ticks        = '0;
            led_phase          = 1'b0;
            pulses_seen        = '0;
            emer_waiting       = 1'b0;
            diag_waiting       = 1'b0;
            display_floor      = '0;
            expected_car_outputs.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_BLINK_HALF_PERIOD) half_period_reg = cfg_wdata;
                else if (cfg_addr == CFG_DIAG_PULSE_LIMIT) pulse_limit_reg = cfg_wdata[7:0];
            end
            // Results come from older words, so they are retired before the
            // word taken at this edge is predicted.
            if (m_tvalid && m_tready) begin
                if (expected_car_outputs.size() == 0) begin
                    $error("result word %h arrived with no expectation waiting", m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_car_outputs.pop_front();
                    got  = m_tdata[8:0];
                    check_field("motor_up", 8'(want.motor_up), 8'(got.motor_up));
                    check_field("motor_down", 8'(want.motor_down), 8'(got.motor_down));
                    check_field("floor_display", 8'(want.floor_display),
                                8'(got.floor_display));
                    check_field("emergency_led", 8'(want.emergency_led),
                                8'(got.emergency_led));
                    check_field("diag_led", 8'(want.diag_led), 8'(got.diag_led));
                    check_field("mode", 8'(want.mode), 8'(got.mode));
                    check_field("zero padding", 8'd0, 8'(m_tdata[15:9]));
                end
            end
            if (s_tvalid && s_tready) begin
                step_car_controller(s_tdata, want);
                expected_car_outputs.push_back(want);
            end
        end
        outputs_pending <= expected_car_outputs.size();
    end

endmodule

/* verif/tb_three_floor_elevator_controller.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the elevator controller. The checker beside the
// block predicts and compares; this module only feeds sample words, drives
// the result side's ready, writes the registers and decides pass or fail.
module tb_three_floor_elevator_controller;
    import elc_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = CFG_BLINK_HALF_PERIOD;
    logic [15:0] cfg_wdata = '0;

    int mismatch_count;
    int outputs_pending;

    // Idle rates in percent for both sides; changed as the run goes on.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Long receiver hold-off: requested by the stimulus, counted below.
    logic hold_go   = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    three_floor_elevator_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    elevator_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .outputs_pending (outputs_pending)
    );

    // Result side. Once the hold-off is requested, ready stays low for a long
    // stretch while the sender keeps offering, so the result register fills
    // and the block must drop s_tready. Otherwise ready follows the idle rate.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_left <= 120;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [15:0] pack_sample(input logic [2:0] sens, input logic [6:0] calls,
                                                input logic emer, input logic pulse,
                                                input logic resume, input logic tick);
        return {2'b00, tick, resume, pulse, emer, calls, sens};
    endfunction

    // Random sample. Most words show the car at exactly one floor or between
    // floors with at most one call pressed, which lets trips, emergencies and
    // diagnostic stops run to completion; the rest are noisy sensor and call
    // patterns. Ticks are frequent so that blink waits can end.
    function automatic logic [15:0] random_sample();
        logic [2:0] sens;
        logic [6:0] calls;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 55) sens = 3'b001 << $urandom_range(2);
        else if (pick < 85) sens = 3'b000;
        else sens = 3'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 45) calls = '0;
        else if (pick < 85) calls = 7'b0000001 << $urandom_range(6);
        else calls = 7'($urandom_range(127));
        return pack_sample(sens, calls, $urandom_range(99) < 3, $urandom_range(99) < 6,
                           $urandom_range(99) < 40, $urandom_range(99) < 60);
    endfunction

    // Offers one word and returns at the edge where it is taken. Called just
    // after a rising edge; valid is only ever assigned once per edge.
    task automatic offer_sample(input logic [15:0] w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Waits until every expected result word has been taken. The pending
    // count is a registered copy, hence the wait for the first edge.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outputs_pending != 0) @(posedge aclk);
    endtask

    // Writes both registers, the half period and then the pulse limit; only while idle.
    task automatic set_config(input logic [15:0] half_period, input logic [7:0] pulse_limit);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_BLINK_HALF_PERIOD;
        cfg_wdata <= half_period;
        @(posedge aclk);
        cfg_addr  <= CFG_DIAG_PULSE_LIMIT;
        cfg_wdata <= {8'd0, pulse_limit};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Short directed walk: a trip in each direction with the call priorities,
    // an emergency with a diagnostic limit reached during it, a diagnostic
    // stop with an emergency held pending, and the field extremes.
    task automatic run_directed();
        offer_sample(pack_sample(3'b000, 7'h00, 0, 0, 0, 0)); // no floor seen yet
        offer_sample(pack_sample(3'b001, 7'h03, 0, 0, 0, 0)); // own-floor call ignored
        offer_sample(pack_sample(3'b001, 7'h7F, 0, 0, 0, 0)); // floor 2 wins from floor 1
        offer_sample(pack_sample(3'b000, 7'h00, 0, 0, 0, 1));
        offer_sample(pack_sample(3'b010, 7'h00, 0, 0, 0, 0)); // arrive at floor 2
        offer_sample(pack_sample(3'b010, 7'h61, 0, 0, 0, 0)); // floor 1 wins from floor 2
        offer_sample(pack_sample(3'b001, 7'h00, 0, 0, 0, 0));
        offer_sample(pack_sample(3'b001, 7'h20, 0, 0, 0, 0)); // up to floor 3
        offer_sample(pack_sample(3'b111, 7'h00, 0, 0, 0, 0)); // all sensors at once
        offer_sample(pack_sample(3'b111, 7'h7F, 0, 0, 0, 0)); // lowest sensor counts
        offer_sample(pack_sample(3'b000, 7'h00, 1, 0, 0, 0)); // emergency while moving
        offer_sample(pack_sample(3'b000, 7'h00, 1, 1, 1, 1)); // repeated edge ignored
        offer_sample(pack_sample(3'b000, 7'h00, 0, 1, 1, 1)); // limit hit in the wait
        offer_sample(pack_sample(3'b100, 7'h00, 1, 0, 0, 0)); // descending, floor 3 only
        offer_sample(pack_sample(3'b011, 7'h00, 0, 0, 0, 0)); // floor 2 preferred, diag stop
        offer_sample(pack_sample(3'b010, 7'h00, 1, 1, 0, 1)); // emergency held in diag wait
        offer_sample(pack_sample(3'b010, 7'h00, 0, 0, 1, 1));
        offer_sample(pack_sample(3'b010, 7'h00, 0, 0, 1, 1)); // served emergency blinks off
        offer_sample(pack_sample(3'b000, 7'h00, 0, 0, 1, 1));
        offer_sample(pack_sample(3'b000, 7'h00, 0, 0, 1, 1));
        offer_sample(pack_sample(3'b001, 7'h00, 0, 0, 0, 0)); // descent ends at floor 1
        offer_sample(pack_sample(3'b100, 7'h03, 0, 0, 0, 0));
        offer_sample(pack_sample(3'b111, 7'h7F, 1, 1, 1, 1)); // every input bit high
        offer_sample(pack_sample(3'b000, 7'h00, 0, 0, 0, 0));
    endtask

    // Register settings per random phase, extremes included: a zero blink
    // period and a zero pulse limit both act as one.
    logic [15:0] phase_half  [5] = '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd2};
    logic [7:0]  phase_limit [5] = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd4};
    int          phase_words [5] = '{250, 250, 300, 100, 350};

    initial begin
        int word_idx;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_config(16'd1, 8'd2);
        tx_idle_pct <= 8;
        rx_idle_pct <= 69;
        run_directed();
        wait_drained();

        word_idx = 0;
        for (int p = 0; p < 5; p++) begin
            set_config(phase_half[p], phase_limit[p]);
            for (int n = 0; n < phase_words[p]; n++) begin
                // Idle pattern follows the random word count: sender rarely
                // idle and receiver mostly stalled, then reversed, then none.
                if (word_idx == 0) begin
                    tx_idle_pct <= 8;
                    rx_idle_pct <= 69;
                end else if (word_idx == 420) begin
                    tx_idle_pct <= 69;
                    rx_idle_pct <= 8;
                end else if (word_idx == 840) begin
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                end
                if (word_idx == 900) hold_go <= 1'b1;
                // Sender stops once mid-phase until all results are back.
                if (word_idx == 1100) wait_drained();
                offer_sample(random_sample());
                word_idx++;
            end
            wait_drained();
        end

        // Catch any stray result word after the last expected one.
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && outputs_pending == 0) begin
            $display("[three_floor_elevator_controller] OK");
        end else begin
            $display("[three_floor_elevator_controller] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[three_floor_elevator_controller] ERROR");
        $finish;
    end

endmodule
